// File: sv/glmr_pkg.sv
package glmr_pkg;

    localparam int HEIGHT_W      = 4;
    localparam int SUM_W         = 18;
    localparam int CNT_W         = 15;
    localparam int SLOT_COUNT    = 3;
    localparam int DEF_MAX_WIDTH = 128;

    // Per-cell control handed from the scan stage to the judging stage
    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                col_ge1;    // a cell to the left exists
        logic                col_ge2;    // two cells to the left exist
        logic                row_end;
        logic                frame_end;
        logic                has_prev;   // a row above exists
        logic                has_prev2;  // two rows above exist
    } t_cell_info;

    // Frame totals: settled rows plus the provisional tally of the final row
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] row_sum;
        logic [CNT_W-1:0] row_cnt;
    } t_frame;

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[CNT_W] ? {CNT_W{1'b1}} : t[CNT_W-1:0];
    endfunction

endpackage

// File: sv/glmr_ifs.sv
interface glmr_cell_if;
    logic                          valid;
    logic                          ready;
    logic [glmr_pkg::HEIGHT_W-1:0] height;
    logic                          end_of_row;
    logic                          last_row;

    modport source (output valid, height, end_of_row, last_row, input ready);
    modport sink   (input valid, height, end_of_row, last_row, output ready);
endinterface

interface glmr_risk_if;
    logic                       valid;
    logic                       ready;
    logic [glmr_pkg::SUM_W-1:0] risk_sum;
    logic [glmr_pkg::CNT_W-1:0] minima_count;

    modport source (output valid, risk_sum, minima_count, input ready);
    modport sink   (input valid, risk_sum, minima_count, output ready);
endinterface

// File: sv/glmr_ram.sv
module glmr_ram #(
    parameter int W     = 4,
    parameter int DEPTH = 384,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [W-1:0]  o_rdata_a,
    output logic [W-1:0]  o_rdata_b
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata_a;
    logic [W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: sv/glmr_scan.sv
module glmr_scan #(
    parameter int MAX_WIDTH = glmr_pkg::DEF_MAX_WIDTH,
    localparam int AW       = $clog2(glmr_pkg::SLOT_COUNT * MAX_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [glmr_pkg::HEIGHT_W-1:0] i_height,
    input  logic                          i_end_of_row,
    input  logic                          i_last_row,
    output logic [AW-1:0]                 o_waddr,
    output logic [AW-1:0]                 o_raddr_prev,
    output logic [AW-1:0]                 o_raddr_up,
    output glmr_pkg::t_cell_info          o_info
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam logic [AW-1:0] BASE1 = AW'(MAX_WIDTH);
    localparam logic [AW-1:0] BASE2 = AW'(2 * MAX_WIDTH);
    localparam logic [2:0]    SLOT0 = 3'b001;

    logic [CW-1:0] r_col,   n_col;
    logic [1:0]    r_rows,  n_rows;   // rows finished, saturating at two
    logic [WW-1:0] r_width, n_width;
    logic [2:0]    r_slot,  n_slot;   // one-hot row slot being written

    logic [WW-1:0] w_col_p1;
    logic          w_first;
    logic          w_row_end;
    logic [2:0]    w_slot_prev;
    logic [2:0]    w_slot_up;

    function automatic logic [AW-1:0] f_base(input logic [2:0] s);
        return ({AW{s[1]}} & BASE1) | ({AW{s[2]}} & BASE2);
    endfunction

    assign w_col_p1    = WW'(r_col) + WW'(1);
    assign w_first     = (r_rows == 2'd0);
    assign w_row_end   = w_first ? (i_end_of_row || (w_col_p1 == WW'(MAX_WIDTH)))
                                 : (w_col_p1 >= r_width);
    assign w_slot_prev = {r_slot[0], r_slot[2:1]};
    assign w_slot_up   = {r_slot[1:0], r_slot[2]};

    assign o_waddr      = f_base(r_slot) + AW'(r_col);
    assign o_raddr_prev = f_base(w_slot_prev) + AW'(r_col);
    assign o_raddr_up   = f_base(w_slot_up) + AW'(r_col);

    always_comb begin
        o_info.height    = i_height;
        o_info.col_ge1   = (r_col != '0);
        o_info.col_ge2   = (r_col > CW'(1));
        o_info.row_end   = w_row_end;
        o_info.frame_end = w_row_end && i_last_row;
        o_info.has_prev  = !w_first;
        o_info.has_prev2 = r_rows[1];
    end

    always_comb begin
        n_col   = r_col;
        n_rows  = r_rows;
        n_width = r_width;
        n_slot  = r_slot;
        if (i_accept) begin
            if (!w_row_end) begin
                n_col = CW'(w_col_p1);
            end else if (i_last_row) begin
                n_col   = '0;
                n_rows  = 2'd0;
                n_width = '0;
                n_slot  = SLOT0;
            end else begin
                n_col  = '0;
                n_slot = w_slot_up;
                if (!r_rows[1]) begin
                    n_rows = r_rows + 2'd1;
                end
                if (w_first) begin
                    n_width = w_col_p1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_rows  <= 2'd0;
            r_width <= '0;
            r_slot  <= SLOT0;
        end else begin
            r_col   <= n_col;
            r_rows  <= n_rows;
            r_width <= n_width;
            r_slot  <= n_slot;
        end
    end

    a_slot_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_slot))
        else $error("row slot pointer lost its one-hot form");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rows != 2'd0) |-> (w_col_p1 <= r_width))
        else $error("column ran past the row width");

endmodule

// File: sv/glmr_judge.sv
module glmr_judge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  glmr_pkg::t_cell_info          i_info,
    input  logic [glmr_pkg::HEIGHT_W-1:0] i_rd_prev,
    input  logic [glmr_pkg::HEIGHT_W-1:0] i_rd_up,
    input  logic                          i_s2_free,
    output logic                          o_busy,
    output logic                          o_frame_valid,
    output glmr_pkg::t_frame              o_frame
);

    localparam int HW = glmr_pkg::HEIGHT_W;
    localparam int SW = glmr_pkg::SUM_W;
    localparam int NW = glmr_pkg::CNT_W;

    logic                 r_valid;
    glmr_pkg::t_cell_info r_info;

    // Sliding window: p = row above, u = two rows above, c = current row
    logic [HW-1:0] r_p1, r_p2, r_u1, r_c1, r_c2;

    logic [SW-1:0] r_sum, n_sum, r_row_sum, n_row_sum;
    logic [NW-1:0] r_cnt, n_cnt, r_row_cnt, n_row_cnt;

    logic          w_retire;
    logic          w_fa, w_fb, w_fc, w_fd;
    logic [HW:0]   w_ia, w_ib, w_ic, w_id;
    logic [SW-1:0] w_row_base;
    logic [NW-1:0] w_row_cbase;

    function automatic logic f_is_min(
        input logic [HW-1:0] v,
        input logic [HW-1:0] up,    input logic up_ok,
        input logic [HW-1:0] left,  input logic left_ok,
        input logic [HW-1:0] right, input logic right_ok,
        input logic [HW-1:0] down,  input logic down_ok
    );
        return (!up_ok || v < up) && (!left_ok || v < left) &&
               (!right_ok || v < right) && (!down_ok || v < down);
    endfunction

    assign o_busy   = r_valid && r_info.frame_end && !i_s2_free;
    assign w_retire = r_valid && !o_busy;

    // Row above, cell to the left of the current column
    assign w_fa = r_info.has_prev && r_info.col_ge1 &&
                  f_is_min(r_p1, r_u1, r_info.has_prev2, r_p2, r_info.col_ge2,
                           i_rd_prev, 1'b1, r_c1, 1'b1);
    // Row above, last cell of the row
    assign w_fb = r_info.has_prev && r_info.row_end &&
                  f_is_min(i_rd_prev, i_rd_up, r_info.has_prev2, r_p1, r_info.col_ge1,
                           r_p1, 1'b0, r_info.height, 1'b1);
    // Current row, provisional (no row below), cell to the left
    assign w_fc = r_info.col_ge1 &&
                  f_is_min(r_c1, r_p1, r_info.has_prev, r_c2, r_info.col_ge2,
                           r_info.height, 1'b1, r_c1, 1'b0);
    // Current row, provisional, last cell of the row
    assign w_fd = r_info.row_end &&
                  f_is_min(r_info.height, i_rd_prev, r_info.has_prev, r_c1, r_info.col_ge1,
                           r_c1, 1'b0, r_c1, 1'b0);

    assign w_ia = w_fa ? ((HW + 1)'(r_p1) + (HW + 1)'(1)) : '0;
    assign w_ib = w_fb ? ((HW + 1)'(i_rd_prev) + (HW + 1)'(1)) : '0;
    assign w_ic = w_fc ? ((HW + 1)'(r_c1) + (HW + 1)'(1)) : '0;
    assign w_id = w_fd ? ((HW + 1)'(r_info.height) + (HW + 1)'(1)) : '0;

    // Provisional tally restarts with each row
    assign w_row_base  = r_info.col_ge1 ? r_row_sum : '0;
    assign w_row_cbase = r_info.col_ge1 ? r_row_cnt : '0;

    always_comb begin
        n_sum     = glmr_pkg::sat_sum(r_sum, SW'(w_ia) + SW'(w_ib));
        n_cnt     = glmr_pkg::sat_cnt(r_cnt, NW'(w_fa) + NW'(w_fb));
        n_row_sum = glmr_pkg::sat_sum(w_row_base, SW'(w_ic) + SW'(w_id));
        n_row_cnt = glmr_pkg::sat_cnt(w_row_cbase, NW'(w_fc) + NW'(w_fd));
    end

    assign o_frame_valid   = w_retire && r_info.frame_end;
    assign o_frame.sum     = n_sum;
    assign o_frame.cnt     = n_cnt;
    assign o_frame.row_sum = n_row_sum;
    assign o_frame.row_cnt = n_row_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_row_sum <= '0;
            r_row_cnt <= '0;
        end else begin
            if (i_load) begin
                r_valid <= 1'b1;
            end else if (w_retire) begin
                r_valid <= 1'b0;
            end
            if (w_retire) begin
                r_sum     <= r_info.frame_end ? '0 : n_sum;
                r_cnt     <= r_info.frame_end ? '0 : n_cnt;
                r_row_sum <= n_row_sum;
                r_row_cnt <= n_row_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_info <= i_info;
        end
        if (w_retire) begin
            r_p2 <= r_p1;
            r_p1 <= i_rd_prev;
            r_u1 <= i_rd_up;
            r_c2 <= r_c1;
            r_c1 <= r_info.height;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || w_retire))
        else $error("new beat loaded over a stalled one");

endmodule

// File: sv/grid_local_minimum_risk_sum_top.sv
// Channel   Dir  Payload                          Beat
// i_cell    in   height[3:0] end_of_row last_row  one map cell, row-major
// o_risk    out  risk_sum[17:0] minima_count[14:0] one total per frame
//
// One cell per clock while i_cell.ready is high: a beat is written to the line
// memory and its two upper neighbours are read in the accept cycle; judging follows in the next cycle.
// A frame total reaches o_risk through the hold stage and the output register.
// Synchronous active-low reset clears the control state only; the line memory
// is read only where the current frame has written it, so it is never cleared.
// i_cell.ready drops only when a frame-end beat waits behind two untaken totals.
module grid_local_minimum_risk_sum_top #(
    parameter int MAX_WIDTH = glmr_pkg::DEF_MAX_WIDTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    glmr_cell_if.sink   i_cell,
    glmr_risk_if.source o_risk
);

    localparam int DEPTH = glmr_pkg::SLOT_COUNT * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int HW    = glmr_pkg::HEIGHT_W;

    logic                 w_accept;
    logic [AW-1:0]        w_waddr, w_raddr_prev, w_raddr_up;
    logic [HW-1:0]        w_rd_prev, w_rd_up;
    glmr_pkg::t_cell_info w_info;

    logic                 w_busy;
    logic                 w_frame_valid;
    glmr_pkg::t_frame     w_frame;
    logic                 w_s2_free;
    logic                 w_out_load;

    // Frame hold stage: totals wait here for the final add
    logic                 r_f_valid;
    glmr_pkg::t_frame     r_f;

    // Output register
    logic                       r_o_valid;
    logic [glmr_pkg::SUM_W-1:0] r_o_sum;
    logic [glmr_pkg::CNT_W-1:0] r_o_cnt;

    assign i_cell.ready = !w_busy;
    assign w_accept     = i_cell.valid && i_cell.ready;

    glmr_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_height     (i_cell.height),
        .i_end_of_row (i_cell.end_of_row),
        .i_last_row   (i_cell.last_row),
        .o_waddr      (w_waddr),
        .o_raddr_prev (w_raddr_prev),
        .o_raddr_up   (w_raddr_up),
        .o_info       (w_info)
    );

    // Writes go to the current row's slot, reads to the two rows above:
    // never the same entry in one cycle.
    glmr_ram #(
        .W     (HW),
        .DEPTH (DEPTH)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_we      (w_accept),
        .i_waddr   (w_waddr),
        .i_wdata   (i_cell.height),
        .i_re      (w_accept),
        .i_raddr_a (w_raddr_prev),
        .i_raddr_b (w_raddr_up),
        .o_rdata_a (w_rd_prev),
        .o_rdata_b (w_rd_up)
    );

    glmr_judge u_judge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_info        (w_info),
        .i_rd_prev     (w_rd_prev),
        .i_rd_up       (w_rd_up),
        .i_s2_free     (w_s2_free),
        .o_busy        (w_busy),
        .o_frame_valid (w_frame_valid),
        .o_frame       (w_frame)
    );

    assign w_out_load = r_f_valid && (!r_o_valid || o_risk.ready);
    assign w_s2_free  = !r_f_valid || w_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_f_valid <= w_frame_valid || (r_f_valid && !w_out_load);
            r_o_valid <= w_out_load || (r_o_valid && !o_risk.ready);
        end
    end

    // Final row's provisional minima join the settled total, saturating
    always_ff @(posedge i_clk) begin
        if (w_frame_valid) begin
            r_f <= w_frame;
        end
        if (w_out_load) begin
            r_o_sum <= glmr_pkg::sat_sum(r_f.sum, r_f.row_sum);
            r_o_cnt <= glmr_pkg::sat_cnt(r_f.cnt, r_f.row_cnt);
        end
    end

    assign o_risk.valid        = r_o_valid;
    assign o_risk.risk_sum     = r_o_sum;
    assign o_risk.minima_count = r_o_cnt;

    a_hold_not_overwritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frame_valid |-> (!r_f_valid || w_out_load))
        else $error("frame total overwrote one still held");

    a_out_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_f_valid))
        else $error("result shown without a held frame total");

endmodule

// File: test/grid_local_minimum_risk_sum_top_tb.sv
`timescale 1ns / 1ps

module grid_local_minimum_risk_sum_top_tb;

    localparam int HEIGHT_W   = glmr_pkg::HEIGHT_W;
    localparam int SUM_W      = glmr_pkg::SUM_W;
    localparam int CNT_W      = glmr_pkg::CNT_W;
    localparam int SLOT_COUNT = glmr_pkg::SLOT_COUNT;

    localparam int LINE_CELLS = glmr_pkg::DEF_MAX_WIDTH;   // cells per row slot
    localparam int RANDOM_BEATS = 870;
    localparam int MIN_FRAMES = 20;                 // random frames, at least
    localparam int HOLD_START = 300;                // receiver cycle of the long hold-off
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES = 10;

    // One beat on the cell channel, plus an optional typed-in total
    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                eor;
        logic                lr;
        logic                fixed;      // total below is typed in, not predicted
        logic [SUM_W-1:0]    fsum;
        logic [CNT_W-1:0]    fcnt;
    } t_map_cell;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } t_frame_total;

    logic i_clk;
    logic i_rst_n;

    glmr_cell_if cell_bus ();
    glmr_risk_if risk_bus ();

    grid_local_minimum_risk_sum_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_bus),
        .o_risk  (risk_bus)
    );

    // ------------------------------------------------------------------
    // Directed beats. Each map is self-contained; the total is typed in on
    // the beat that closes the frame.
    //   lone cell at the top height, lone cell at zero
    //   one row 9 0 9 with last_row on every cell (only the row end counts)
    //   one column 5 / 2 / 7, later rows with end_of_row both high and low
    //   flat 2x2 plateau: equal neighbours never make a minimum
    //   2x2 of 0 15 / 15 0: both zeros are minima
    //   3x3 bowl with a stray last_row inside the middle row
    // ------------------------------------------------------------------
    localparam int DIRECTED_BEATS = 25;
    localparam t_map_cell DIRECTED [DIRECTED_BEATS] = '{
        '{4'd15, 1'b1, 1'b1, 1'b1, 18'd16, 15'd1},
        '{4'd0,  1'b1, 1'b1, 1'b1, 18'd1,  15'd1},
        '{4'd9,  1'b0, 1'b1, 1'b0, 18'd0,  15'd0},
        '{4'd0,  1'b0, 1'b1, 1'b0, 18'd0,  15'd0},
        '{4'd9,  1'b1, 1'b1, 1'b1, 18'd1,  15'd1},
        '{4'd5,  1'b1, 1'b0, 1'b0, 18'd0,  15'd0},
        '{4'd2,  1'b1, 1'b0, 1'b0, 18'd0,  15'd0},
        '{4'd7,  1'b0, 1'b1, 1'b1, 18'd3,  15'd1},
        '{4'd4,  1'b0, 1'b0, 1'b0, 18'd0,  15'd0},
        '{4'd4,  1'b1, 1'b0, 1'b0, 18'd0,  15'd0},
        '{4'd4,  1'b0, 1'b1, 1'b0, 18'd0,  15'd0},
        '{4'd4,  1'b1, 1'b1, 1'b1, 18'd0,  15'd0},
        '{4'd0,  1'b0, 1'b0, 1'b0, 18'd0,  15'd0},
        '{4'd15, 1'b1, 1'b0, 1'b0, 18'd0,  15'd0},
        '{4'd15, 1'b0, 1'b1, 1'b0, 18'd0,  15'd0},
        '{4'd0,  1'b1, 1'b1, 1'b1, 18'd2,  15'd2},
        '{4'd9,  1'b0, 1'b0, 1'b0, 18'd0,  15'd0},
        '{4'd9,  1'b0, 1'b0, 1'b0, 18'd0,  15'd0},
        '{4'd9,  1'b1, 1'b0, 1'b0, 18'd0,  15'd0},
        '{4'd9,  1'b0, 1'b0, 1'b0, 18'd0,  15'd0},
        '{4'd3,  1'b0, 1'b1, 1'b0, 18'd0,  15'd0},
        '{4'd9,  1'b1, 1'b0, 1'b0, 18'd0,  15'd0},
        '{4'd9,  1'b0, 1'b1, 1'b0, 18'd0,  15'd0},
        '{4'd9,  1'b0, 1'b1, 1'b0, 18'd0,  15'd0},
        '{4'd9,  1'b1, 1'b1, 1'b1, 18'd4,  15'd1}
    };

    // ------------------------------------------------------------------
    // Minimum finder: three row slots, scan position and frame tallies
    // ------------------------------------------------------------------
    logic [HEIGHT_W-1:0] line_mem [SLOT_COUNT][LINE_CELLS];
    int unsigned         scan_col = 0;
    int unsigned         rows_seen = 0;     // saturates at 255
    int unsigned         row_len = 0;       // fixed by the first row
    int unsigned         fill_slot = 0;
    logic [SUM_W-1:0]    risk_acc = '0;
    logic [CNT_W-1:0]    minima_acc = '0;

    t_map_cell    feed_q [$];
    t_frame_total totals_due [$];
    t_frame_total got_total;
    t_frame_total due_total;
    int unsigned  mismatches = 0;

    // Decide one stored cell; 'below' is the arriving cell when has_down
    function automatic void judge_cell(input int unsigned s, input int unsigned c,
                                       input bit has_up, input int unsigned up_s,
                                       input bit has_down, input logic [HEIGHT_W-1:0] below);
        logic [HEIGHT_W-1:0] v;
        bit                  lowest;
        logic [SUM_W:0]      t;
        v = line_mem[s][c];
        lowest = 1'b1;
        if (has_up && v >= line_mem[up_s][c])
            lowest = 1'b0;
        if (c > 0 && v >= line_mem[s][c-1])
            lowest = 1'b0;
        if (c + 1 < row_len && v >= line_mem[s][c+1])
            lowest = 1'b0;
        if (has_down && v >= below)
            lowest = 1'b0;
        if (lowest) begin
            t = {1'b0, risk_acc} + (SUM_W+1)'(v) + (SUM_W+1)'(1);
            risk_acc = t[SUM_W] ? '1 : t[SUM_W-1:0];
            if (minima_acc != '1)
                minima_acc = minima_acc + 1'b1;
        end
    endfunction

    // Advance the scan by one accepted cell; returns 1 when a frame closes
    function automatic bit scan_cell(input logic [HEIGHT_W-1:0] h, input bit eor,
                                     input bit lr, output t_frame_total tot);
        int unsigned col;
        int unsigned prev_s;
        int unsigned prev2_s;
        bit          row_end;
        tot = '0;
        col = scan_col % LINE_CELLS;
        prev_s = (fill_slot + 2) % SLOT_COUNT;
        prev2_s = (fill_slot + 1) % SLOT_COUNT;

        // the cell above the arrival is now complete on all four sides
        if (rows_seen >= 1)
            judge_cell(prev_s, col, rows_seen >= 2, prev2_s, 1'b1, h);
        line_mem[fill_slot][col] = h;

        if (rows_seen == 0)
            row_end = eor || (col + 1 >= LINE_CELLS);
        else
            row_end = (col + 1 >= row_len);
        if (!row_end) begin
            scan_col = col + 1;
            return 1'b0;
        end
        if (rows_seen == 0)
            row_len = col + 1;

        if (lr) begin
            // final row has no row below it
            for (int unsigned c = 0; c < row_len; c++)
                judge_cell(fill_slot, c, rows_seen >= 1, prev_s, 1'b0, '0);
            tot.sum = risk_acc;
            tot.cnt = minima_acc;
            scan_col = 0;
            rows_seen = 0;
            row_len = 0;
            fill_slot = 0;
            risk_acc = '0;
            minima_acc = '0;
            return 1'b1;
        end

        scan_col = 0;
        fill_slot = (fill_slot + 1) % SLOT_COUNT;
        if (rows_seen < 255)
            rows_seen++;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic void push_cell(input logic [HEIGHT_W-1:0] h, input bit eor,
                                      input bit lr);
        t_map_cell mc;
        mc = '0;
        mc.height = h;
        mc.eor = eor;
        mc.lr = lr;
        feed_q.insert(feed_q.size(), mc);
    endfunction

    // flavour: 0 digits, 1 full 4-bit range, 2 narrow band (lots of ties),
    //          3 stray marks, 4 ragged rows that the block regroups
    function automatic void add_frame(input int unsigned w, input int unsigned rows,
                                      input int unsigned flavour, input bit omit_mark);
        int unsigned         len;
        int unsigned         band;
        logic [HEIGHT_W-1:0] h;
        bit                  eor;
        bit                  lr;
        band = $urandom_range(0, 14);
        for (int unsigned r = 0; r < rows; r++) begin
            len = w;
            if (flavour == 4 && r > 0 && $urandom_range(0, 2) == 0)
                len = $urandom_range(1, w + 2);
            for (int unsigned c = 0; c < len; c++) begin
                case (flavour)
                    1: h = HEIGHT_W'($urandom_range(0, 15));
                    2: h = HEIGHT_W'(band + $urandom_range(0, 1));
                    default: h = HEIGHT_W'($urandom_range(0, 9));
                endcase
                eor = (c == len - 1);
                if (r == 0 && omit_mark)
                    eor = 1'b0;     // first row ends on the width limit instead
                lr = (r == rows - 1);
                if (flavour == 3) begin
                    if (r > 0)
                        eor = 1'($urandom_range(0, 1));
                    if (c != len - 1)
                        lr = 1'($urandom_range(0, 1));
                end
                push_cell(h, eor, lr);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: one beat, prediction taken at the accepting edge
    // ------------------------------------------------------------------
    task automatic offer_cell(input t_map_cell mc);
        t_frame_total tot;
        cell_bus.valid <= 1'b1;
        cell_bus.height <= mc.height;
        cell_bus.end_of_row <= mc.eor;
        cell_bus.last_row <= mc.lr;
        do
            @(posedge i_clk);
        while (cell_bus.ready !== 1'b1);
        if (scan_cell(mc.height, mc.eor, mc.lr, tot)) begin
            if (mc.fixed) begin
                tot.sum = mc.fsum;
                tot.cnt = mc.fcnt;
            end
            totals_due.insert(totals_due.size(), tot);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Safety net: several times the slowest legal run
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, build all beats, feed them in bursts, drain
    // ------------------------------------------------------------------
    initial begin
        int unsigned frames_made;
        int unsigned idx;
        int unsigned burst;
        int unsigned gap;
        int unsigned w;
        int unsigned rows;

        i_rst_n <= 1'b0;
        cell_bus.valid <= 1'b0;
        cell_bus.height <= '0;
        cell_bus.end_of_row <= 1'b0;
        cell_bus.last_row <= 1'b0;

        for (int i = 0; i < DIRECTED_BEATS; i++)
            feed_q.insert(feed_q.size(), DIRECTED[i]);

        // Random frames: mostly small and well formed, some wide, some broken
        frames_made = 0;
        while (feed_q.size() < DIRECTED_BEATS + RANDOM_BEATS || frames_made < MIN_FRAMES) begin
            if ($urandom_range(0, 19) == 0) begin
                w = LINE_CELLS;
                rows = $urandom_range(1, 3);
                add_frame(w, rows, $urandom_range(0, 2), 1'($urandom_range(0, 1)));
            end else begin
                w = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
                rows = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
                if ($urandom_range(0, 4) == 0)
                    add_frame(w, rows, $urandom_range(3, 4), 1'b0);
                else
                    add_frame(w, rows, $urandom_range(0, 2), 1'b0);
            end
            frames_made++;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bursts of random length, gaps of random length, some long bursts
        idx = 0;
        while (idx < feed_q.size()) begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 24);
            for (int unsigned k = 0; k < burst && idx < feed_q.size(); k++) begin
                offer_cell(feed_q[idx]);
                idx++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                cell_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        cell_bus.valid <= 1'b0;

        while (totals_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: segments of always-ready, half-ready and mostly-stalled,
    // with one long hold-off so that totals back up and the cell channel
    // is throttled
    // ------------------------------------------------------------------
    initial begin
        int unsigned seg_len;
        int unsigned mode;
        int unsigned rx_cycle;

        risk_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        rx_cycle = 0;
        forever begin
            seg_len = $urandom_range(8, 80);
            mode = $urandom_range(0, 2);
            repeat (seg_len) begin
                @(posedge i_clk);
                rx_cycle++;
                if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
                    risk_bus.ready <= 1'b0;
                else if (mode == 0)
                    risk_bus.ready <= 1'b1;
                else if (mode == 1)
                    risk_bus.ready <= 1'($urandom_range(0, 1));
                else
                    risk_bus.ready <= ($urandom_range(0, 4) == 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Total checker: every accepted beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && risk_bus.valid === 1'b1 && risk_bus.ready === 1'b1) begin
            got_total.sum = risk_bus.risk_sum;
            got_total.cnt = risk_bus.minima_count;
            if (totals_due.size() == 0) begin
                $error("frame total with none expected: risk_sum %0d minima_count %0d",
                       got_total.sum, got_total.cnt);
                mismatches++;
            end else begin
                due_total = totals_due.pop_front();
                if (got_total.sum !== due_total.sum) begin
                    $error("risk_sum: expected %0d, got %0d", due_total.sum, got_total.sum);
                    mismatches++;
                end
                if (got_total.cnt !== due_total.cnt) begin
                    $error("minima_count: expected %0d, got %0d",
                           due_total.cnt, got_total.cnt);
                    mismatches++;
                end
            end
        end
    end

endmodule

// File: grid_local_minimum_risk_sum_top.f
sv/glmr_pkg.sv
sv/glmr_ifs.sv
sv/glmr_ram.sv
sv/glmr_scan.sv
sv/glmr_judge.sv
sv/grid_local_minimum_risk_sum_top.sv
test/grid_local_minimum_risk_sum_top_tb.sv
